// File: sv/scfd_pkg.sv
// shared constants and types for the sync crc32 frame deframer
// no dependencies
`default_nettype none
package scfd_pkg;
   localparam int Samples    = 32;
   localparam int SyncBytes  = 4;
   localparam int CrcBytes   = 4;
   localparam int DataBytes  = 4 * Samples;
   localparam int FrameBytes = SyncBytes + DataBytes + CrcBytes;
   localparam int AddrW      = $clog2(FrameBytes);
   localparam int CountW     = $clog2(FrameBytes + 1);
   localparam int SampW      = $clog2(Samples);
   localparam logic [31:0] CrcPoly   = 32'hEDB88320;
   localparam logic [31:0] CrcInit   = 32'hFFFFFFFF;
   localparam logic [31:0] SyncReset = 32'hAA55AA55;
   localparam int QDepth = 4;
   localparam int QAddrW = $clog2(QDepth);

   typedef struct packed {
      logic signed [31:0] sample;
      logic               last_sample;
      logic               crc_error;
   } rsp_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
      logic [31:0] r;
      r = c ^ {24'd0, d};
      for (int b = 0; b < 8; b++) begin
         r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
      end
      return r;
   endfunction
endpackage
`default_nettype wire

// File: sv/sync_crc32_frame_deframer_top.sv
// top level of the sync crc32 frame deframer
// depends on scfd_pkg, scfd_engine and scfd_queue (scfd_ram through scfd_engine)
`default_nettype none
// Received bytes are pushed one per request into a 136-byte ring store
// (sync word, 32 little-endian samples, little-endian crc-32). A byte that
// does not fill the store is simply written to it. The byte that fills it
// starts a sequential pass of the frame engine over the store through the
// single read port of the ram, one byte per cycle: a sync search, then on
// an aligned frame a crc pass and a check step, and on a good frame the
// readout of each sample (four byte reads and the hand-off), which waits
// while the queue is full. A good frame gives 32 sample responses, the final
// one with last_sample set; a bad crc gives one response with crc_error set.
// Responses pass through a 4-entry queue; when it is full the engine waits.
// csr_wr_en loads the sync word, first received byte in the top bits; write
// it only while the block is idle. Reset value 0xAA55AA55.
module sync_crc32_frame_deframer_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic signed [31:0]      rsp_sample,
   output logic                    rsp_last_sample,
   output logic                    rsp_crc_error,
   input  wire logic               csr_wr_en,
   input  wire logic [31:0]        csr_sync_word
);
   logic [31:0]       sync_ff;
   logic              eng_ready, eng_valid, q_full;
   scfd_pkg::rsp_type eng_data, q_data;

   // sync word register
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= scfd_pkg::SyncReset;
      end else if (csr_wr_en) begin
         sync_ff <= csr_sync_word;
      end
   end

   assign req_full = !eng_ready;

   scfd_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_push),
      .in_byte  (req_rx_byte),
      .in_ready (eng_ready),
      .sync_word(sync_ff),
      .out_valid(eng_valid),
      .out_data (eng_data),
      .out_full (q_full)
   );

   // response queue decouples the engine from the consumer
   scfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (eng_valid),
      .push_data(eng_data),
      .full     (q_full),
      .empty    (rsp_empty),
      .pop      (rsp_pop),
      .pop_data (q_data)
   );

   assign rsp_sample      = q_data.sample;
   assign rsp_last_sample = q_data.last_sample;
   assign rsp_crc_error   = q_data.crc_error;
endmodule
`default_nettype wire

// File: sv/scfd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module scfd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: sv/scfd_queue.sv
// short result queue between the frame engine and the result port
// depends on scfd_pkg
`default_nettype none
module scfd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire scfd_pkg::rsp_type push_data,
   output logic                  full,
   output logic                  empty,
   input  wire logic             pop,
   output scfd_pkg::rsp_type     pop_data
);
   scfd_pkg::rsp_type slot_ff [scfd_pkg::QDepth];
   logic [scfd_pkg::QAddrW-1:0] wp_ff, rp_ff;
   logic [scfd_pkg::QAddrW:0]   cnt_ff;
   logic do_push, do_pop;

   assign full     = (cnt_ff == (scfd_pkg::QAddrW+1)'(scfd_pkg::QDepth));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= wp_ff + 1'b1;
         if (do_pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (scfd_pkg::QAddrW+1)'(do_push)
                          - (scfd_pkg::QAddrW+1)'(do_pop);
      end
   end
endmodule
`default_nettype wire

// File: sv/scfd_engine.sv
// frame engine: byte ring store, sync search, crc check and sample readout
// depends on scfd_pkg and scfd_ram
`default_nettype none
module scfd_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [7:0]        in_byte,
   output logic                   in_ready,
   input  wire logic [31:0]       sync_word,
   output logic                   out_valid,
   output scfd_pkg::rsp_type      out_data,
   input  wire logic              out_full
);
   localparam int AW = scfd_pkg::AddrW;
   localparam int CW = scfd_pkg::CountW;
   localparam logic [CW-1:0] Full = CW'(scfd_pkg::FrameBytes);
   localparam logic [CW-1:0] SyncEnd = CW'(scfd_pkg::SyncBytes);
   localparam logic [CW-1:0] DataEnd = CW'(scfd_pkg::SyncBytes + scfd_pkg::DataBytes);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEARCH = 6'b000010,
      ST_CRC    = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_EMIT   = 6'b010000,
      ST_ERR    = 6'b100000
   } state_type;

   state_type       st_ff, st_in;
   logic [AW-1:0]   head_ff, head_in;     // ring position of oldest byte
   logic [CW-1:0]   fill_ff, fill_in;
   logic [CW-1:0]   pos_ff, pos_in;       // read offset issued to the ram
   logic            rv_ff, rv_in;         // read data valid next cycle
   logic [CW-1:0]   rpos_ff, rpos_in;     // offset of data now on rd_data
   logic [31:0]     win_ff, win_in;       // last bytes read; newest low in search, newest high in readout
   logic [31:0]     crc_ff, crc_in;
   logic [31:0]     rx_crc_ff, rx_crc_in;
   logic [scfd_pkg::SampW-1:0] sidx_ff, sidx_in;
   logic [1:0]      bcnt_ff, bcnt_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [7:0]      rd_data;
   logic [CW:0]     wsum, rsum;

   function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
      return (s >= (CW+1)'(scfd_pkg::FrameBytes)) ?
             AW'(s - (CW+1)'(scfd_pkg::FrameBytes)) : AW'(s);
   endfunction

   assign in_ready = (st_ff == ST_IDLE);
   assign wr_en    = in_valid && in_ready;
   assign wsum     = (CW+1)'(head_ff) + (CW+1)'(fill_ff);
   assign wr_addr  = wrap(wsum);
   assign rsum     = (CW+1)'(head_ff) + (CW+1)'(pos_ff);
   assign rd_addr  = wrap(rsum);

   scfd_ram #(.Width(8), .Depth(scfd_pkg::FrameBytes)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(in_byte),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      logic [31:0] w;
      logic [31:0] smp;
      logic [CW:0] hs;
      w         = {win_ff[23:0], rd_data};
      smp       = '0;
      st_in     = st_ff;
      head_in   = head_ff;
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      rv_in     = 1'b0;
      rpos_in   = pos_ff;
      win_in    = win_ff;
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      sidx_in   = sidx_ff;
      bcnt_in   = bcnt_ff;
      out_valid = 1'b0;
      out_data  = '{sample: 32'sd0, last_sample: 1'b0, crc_error: 1'b0};
      hs        = '0;
      unique case (st_ff)
         ST_IDLE: begin
            if (wr_en) begin
               fill_in = fill_ff + 1'b1;
               if (fill_ff + 1'b1 == Full) begin
                  st_in  = ST_SEARCH;
                  pos_in = '0;
               end
            end
         end
         ST_SEARCH: begin
            // issue reads sequentially, compare on the returning byte
            if (pos_ff != Full) begin
               pos_in = pos_ff + 1'b1;
               rv_in  = 1'b1;
            end
            if (rv_ff) begin
               win_in = w;
               if (rpos_ff >= CW'(3) && w == sync_word) begin
                  if (rpos_ff == CW'(3)) begin
                     st_in  = ST_CRC;
                     pos_in = SyncEnd;
                     rv_in  = 1'b0;
                     crc_in = scfd_pkg::CrcInit;
                  end else begin
                     hs      = (CW+1)'(head_ff) + (CW+1)'(rpos_ff - CW'(3));
                     head_in = wrap(hs);
                     fill_in = Full - (rpos_ff - CW'(3));
                     st_in   = ST_IDLE;
                     rv_in   = 1'b0;
                  end
               end else if (rpos_ff == Full - 1'b1) begin
                  hs      = (CW+1)'(head_ff) + (CW+1)'(Full - CW'(3));
                  head_in = wrap(hs);
                  fill_in = CW'(3);
                  st_in   = ST_IDLE;
                  rv_in   = 1'b0;
               end
            end
         end
         ST_CRC: begin
            if (pos_ff != Full) begin
               pos_in = pos_ff + 1'b1;
               rv_in  = 1'b1;
            end
            if (rv_ff) begin
               if (rpos_ff < DataEnd) begin
                  crc_in = scfd_pkg::crc_byte(crc_ff, rd_data);
               end else begin
                  rx_crc_in = {rd_data, rx_crc_ff[31:8]};
               end
               if (rpos_ff == Full - 1'b1) begin
                  st_in = ST_CHECK;
                  rv_in = 1'b0;
               end
            end
         end
         ST_CHECK: begin
            if ((crc_ff ^ scfd_pkg::CrcInit) == rx_crc_ff) begin
               st_in   = ST_EMIT;
               pos_in  = SyncEnd;
               sidx_in = '0;
               bcnt_in = '0;
            end else begin
               st_in = ST_ERR;
            end
         end
         ST_EMIT: begin
            if (bcnt_ff != 2'd3) begin
               // fetch the four bytes of one sample, oldest byte lowest
               if (rv_ff) begin
                  win_in  = {rd_data, win_ff[31:8]};
                  bcnt_in = bcnt_ff + 1'b1;
               end
               pos_in = pos_ff + 1'b1;
               rv_in  = 1'b1;
            end else begin
               // sample complete on the fourth byte, then held in win_ff
               // until the queue has room
               smp    = rv_ff ? {rd_data, win_ff[31:8]} : win_ff;
               win_in = smp;
               if (!out_full) begin
                  out_valid = 1'b1;
                  out_data  = '{sample: signed'(smp),
                                last_sample: (sidx_ff == scfd_pkg::SampW'(scfd_pkg::Samples-1)),
                                crc_error: 1'b0};
                  bcnt_in = '0;
                  sidx_in = sidx_ff + 1'b1;
                  if (sidx_ff == scfd_pkg::SampW'(scfd_pkg::Samples-1)) begin
                     st_in   = ST_IDLE;
                     fill_in = '0;
                  end
               end
            end
         end
         ST_ERR: begin
            if (!out_full) begin
               out_valid = 1'b1;
               out_data  = '{sample: 32'sd0, last_sample: 1'b0, crc_error: 1'b1};
               hs        = (CW+1)'(head_ff) + (CW+1)'(1);
               head_in   = wrap(hs);
               fill_in   = Full - 1'b1;
               st_in     = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         head_ff <= '0;
         fill_ff <= '0;
         rv_ff   <= 1'b0;
         pos_ff  <= '0;
         rpos_ff <= '0;
         sidx_ff <= '0;
         bcnt_ff <= '0;
      end else begin
         st_ff   <= st_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
         rv_ff   <= rv_in;
         pos_ff  <= pos_in;
         rpos_ff <= rpos_in;
         sidx_ff <= sidx_in;
         bcnt_ff <= bcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff    <= win_in;
      crc_ff    <= crc_in;
      rx_crc_ff <= rx_crc_in;
   end
endmodule
`default_nettype wire
